// ----- rtl/core/oui_pkg.sv -----
`default_nettype none
package oui_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 32768;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PTR_W       = ADDR_W + 1;

	// fixed field widths
	localparam int IDX_W  = 15;
	localparam int KEY_W  = 24;
	localparam int WIDE_W = 17;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FIRST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LAST  = 1'd1;

	// request kinds
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_PROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;      // start a search: take bounds and key
		logic write;     // store key at entry index
		logic issue;     // first probe of a search
		logic probe;     // compare returned entry, step bounds
		logic hit;       // finish with a match at current probe
		logic miss;      // finish with no match
		logic out_load;  // move finished result to the output register
	} cmd_t;

	typedef struct packed {
		logic empty;       // range already empty at issue
		logic hit;         // probed entry equals key
		logic next_empty;  // range empty after this step
	} status_t;

	// saturate a configured bound to the last table index
	function automatic logic [ADDR_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
		logic [WIDE_W-1:0] w;
		logic [WIDE_W-1:0] top;
		w   = {{(WIDE_W-IDX_W){1'b0}}, v};
		top = WIDE_W'(TABLE_DEPTH - 1);
		if (w > top) begin
			w = top;
		end
		return w[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/oui_ram.sv -----
`default_nettype none
module oui_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/oui_ctrl.sv -----
`default_nettype none
module oui_ctrl
	import oui_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_op,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_nxt = (in_op == OP_SEARCH) ? ST_ISSUE : ST_DONE;
				end
			end
			ST_ISSUE: begin
				state_nxt = sts.empty ? ST_DONE : ST_PROBE;
			end
			ST_PROBE: begin
				if (sts.hit || sts.next_empty) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid && (in_op == OP_SEARCH);
				cmd.write = in_valid && (in_op == OP_WRITE);
				cmd.miss  = in_valid && (in_op == OP_WRITE);
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.miss  = sts.empty;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				cmd.hit   = sts.hit;
				cmd.miss  = !sts.hit && sts.next_empty;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/oui_dpath.sv -----
`default_nettype none
module oui_dpath
	import oui_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [IDX_W-1:0]     cfg_wdata,
	input  wire logic [IDX_W-1:0]     entry_index,
	input  wire logic [KEY_W-1:0]     oui_key,
	input  wire cmd_t                 cmd,
	output status_t                   sts,
	output logic                      found,
	output logic [IDX_W-1:0]          match_index
);

	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  last_q;
	logic [PTR_W-1:0]  lo_q;
	logic [PTR_W-1:0]  hip1_q;   // one past the highest index still in range
	logic [ADDR_W-1:0] mid_q;
	logic [KEY_W-1:0]  key_q;
	logic              pend_found_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  match_q;

	logic [KEY_W-1:0]  rdata;
	logic [ADDR_W-1:0] ram_addr;
	logic              ram_we;
	logic [WIDE_W-1:0] wr_wide;
	logic [ADDR_W-1:0] first_c;
	logic [ADDR_W-1:0] last_c;
	logic [PTR_W-1:0]  mid_e;
	logic [PTR_W-1:0]  mid_cur;
	logic [PTR_W-1:0]  lo_a;
	logic [PTR_W-1:0]  mid_a;
	logic [PTR_W-1:0]  mid_b;
	logic              empty_a;
	logic              empty_b;
	logic              lt;
	logic [ADDR_W-1:0] mid_n;
	logic [WIDE_W-1:0] mid_wide;

	assign first_c = clamp_idx(first_q);
	assign last_c  = clamp_idx(last_q);
	assign wr_wide = {{(WIDE_W-IDX_W){1'b0}}, entry_index};
	assign ram_we  = cmd.write && (wr_wide < WIDE_W'(TABLE_DEPTH));

	// probe address of the range held in lo/hip1
	assign mid_cur = lo_q + ((hip1_q - PTR_W'(1) - lo_q) >> 1);

	// both possible next probes are formed from registers; the compare only selects
	assign mid_e   = {1'b0, mid_q};
	assign lo_a    = mid_e + PTR_W'(1);
	assign mid_a   = lo_a + ((hip1_q - PTR_W'(1) - lo_a) >> 1);
	assign mid_b   = lo_q + ((mid_e - PTR_W'(1) - lo_q) >> 1);
	assign empty_a = lo_a >= hip1_q;
	assign empty_b = lo_q >= mid_e;
	assign lt      = rdata < key_q;
	assign mid_n   = lt ? mid_a[ADDR_W-1:0] : mid_b[ADDR_W-1:0];

	assign sts.empty      = lo_q >= hip1_q;
	assign sts.hit        = rdata == key_q;
	assign sts.next_empty = lt ? empty_a : empty_b;

	always_comb begin
		if (cmd.write) begin
			ram_addr = wr_wide[ADDR_W-1:0];
		end else if (cmd.issue) begin
			ram_addr = mid_cur[ADDR_W-1:0];
		end else begin
			ram_addr = mid_n;
		end
	end

	oui_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(oui_key),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SEARCH_FIRST: first_q <= cfg_wdata;
				CFG_SEARCH_LAST:  last_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign mid_wide = {{(WIDE_W-ADDR_W){1'b0}}, mid_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q   <= {1'b0, first_c};
			hip1_q <= {1'b0, last_c} + PTR_W'(1);
			key_q  <= oui_key;
		end else if (cmd.issue) begin
			mid_q <= mid_cur[ADDR_W-1:0];
		end else if (cmd.probe) begin
			if (lt) begin
				lo_q <= lo_a;
			end else begin
				hip1_q <= mid_e;
			end
			mid_q <= mid_n;
		end
		if (cmd.hit) begin
			pend_found_q <= 1'b1;
			pend_idx_q   <= mid_wide[IDX_W-1:0];
		end else if (cmd.miss) begin
			pend_found_q <= 1'b0;
			pend_idx_q   <= '0;
		end
		if (cmd.out_load) begin
			found_q <= pend_found_q;
			match_q <= pend_idx_q;
		end
	end

	assign found       = found_q;
	assign match_index = match_q;

endmodule
`default_nettype wire

// ----- rtl/core/oui_binary_search.sv -----
// A write goes from acceptance straight to ST_DONE, where its result is registered; a
// search first passes ST_ISSUE and P probes in ST_PROBE (P = 0 to ADDR_W + 1, 16 here).
// One item at a time; the next item is taken the cycle after the result is registered,
// and ST_DONE holds while the output register is full and not being read.
// One probe per cycle, bound by the single port of the key table RAM.
// Reset (arst_n, async low) clears control and config; table contents stay undefined.
`default_nettype none
module oui_binary_search
	import oui_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [39:0]          s_axis_tdata,  // entry_index[14:0], oui_key[38:15], pad
	input  wire logic                 s_axis_tuser,  // operation
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // match_index[14:0], pad
	output logic                      m_axis_tuser,  // found
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [IDX_W-1:0]     cfg_data
);

	cmd_t             cmd;
	status_t          sts;
	logic             found;
	logic [IDX_W-1:0] match_index;

	assign cfg_ready = 1'b1;

	oui_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	oui_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.entry_index(s_axis_tdata[IDX_W-1:0]),
		.oui_key    (s_axis_tdata[IDX_W+KEY_W-1:IDX_W]),
		.cmd        (cmd),
		.sts        (sts),
		.found      (found),
		.match_index(match_index)
	);

	assign m_axis_tuser = found;
	assign m_axis_tdata = {1'b0, match_index};

`ifndef SYNTH
	// a miss always reports index zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
		else $error("miss result with nonzero index");

	// one request in flight: intake closes right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// a new result only appears while the engine is busy finishing a request
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result produced without a request");
`endif

endmodule
`default_nettype wire

// ----- bench/oui_binary_search_checker.sv -----
`timescale 1ns / 100ps
module oui_binary_search_checker
	import oui_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tready,
	input  wire logic [39:0]          s_axis_tdata,  // entry_index[14:0], oui_key[38:15], pad
	input  wire logic                 s_axis_tuser,  // operation
	input  wire logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	input  wire logic [15:0]          m_axis_tdata,  // match_index[14:0], pad
	input  wire logic                 m_axis_tuser,  // found
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [IDX_W-1:0]     cfg_data,
	output int                        mismatches,
	output int                        outstanding
);

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} lookup_t;

	bit   [KEY_W-1:0] key_table [TABLE_DEPTH];
	logic [IDX_W-1:0] span_first;
	logic [IDX_W-1:0] span_last;
	lookup_t          lookups_due [$];

	// inclusive bisection over the configured span, bounds saturated to the table
	function automatic lookup_t search_table(input logic [KEY_W-1:0] key);
		lookup_t hit;
		int      lo;
		int      hi;
		int      mid;
		hit = '0;
		lo  = (int'(span_first) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(span_first);
		hi  = (int'(span_last) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(span_last);
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (key_table[mid] == key) begin
				hit.found = 1'b1;
				hit.index = IDX_W'(mid);
				return hit;
			end
			if (key_table[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_t due;
		if (!arst_n) begin
			span_first = '0;
			span_last  = '1;
			lookups_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SEARCH_FIRST: span_first = cfg_data;
					CFG_SEARCH_LAST:  span_last  = cfg_data;
					default: ;
				endcase
			end
			// result first: a request taken on the same edge is behind it in line
			if (m_axis_tvalid && m_axis_tready) begin
				if (lookups_due.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					due = lookups_due.pop_front();
					if (m_axis_tuser !== due.found)
						report_mismatch($sformatf("found %b, predicted %b",
							m_axis_tuser, due.found));
					if (m_axis_tdata[IDX_W-1:0] !== due.index)
						report_mismatch($sformatf("match_index %0d, predicted %0d",
							m_axis_tdata[IDX_W-1:0], due.index));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == OP_WRITE) begin
					if (int'(s_axis_tdata[IDX_W-1:0]) < TABLE_DEPTH)
						key_table[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[IDX_W +: KEY_W];
					lookups_due.push_back('0);
				end else begin
					lookups_due.push_back(search_table(s_axis_tdata[IDX_W +: KEY_W]));
				end
			end
		end
		outstanding = lookups_due.size();
	end

endmodule

// ----- bench/oui_binary_search_test.sv -----
`timescale 1ns / 100ps
module oui_binary_search_test;
	import oui_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int WIN_MAX      = 1024;
	localparam int HOLD_CYCLES  = 400;

	typedef enum {SPAN_EMPTY, SPAN_LOW, SPAN_HIGH, SPAN_SINGLE, SPAN_WIDE, SPAN_MID} span_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [39:0]          s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [IDX_W-1:0]     cfg_data      = '0;
	int                   mismatches;
	int                   outstanding;

	int       requests_sent;
	int       burst_left;
	int       hold_asked;
	int       hold_given;
	int       hold_left;
	int       mode_left;
	int       cycles;
	rx_mode_t ready_mode;
	bit [7:0] stall_bits;

	oui_binary_search u_dut (.*);

	oui_binary_search_checker u_check (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall modes, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_given != hold_asked) begin
			hold_given++;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(16, 200);
				stall_bits = 8'($urandom()) | 8'h01;
			end
			mode_left--;
			case (ready_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: begin
					m_axis_tready <= stall_bits[0];
					stall_bits = {stall_bits[0], stall_bits[7:1]};
				end
			endcase
		end
	end

	// called and returns at a falling edge
	task automatic send_req(input logic op, input logic [IDX_W-1:0] idx,
			input logic [KEY_W-1:0] key);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, key, idx};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= IDX_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_range(input int first, input int last);
		wait_idle();
		if ($urandom_range(0, 1)) begin
			cfg_write(CFG_SEARCH_FIRST, first);
			cfg_write(CFG_SEARCH_LAST, last);
		end else begin
			cfg_write(CFG_SEARCH_LAST, last);
			cfg_write(CFG_SEARCH_FIRST, first);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [KEY_W-1:0] ladder [8];
		logic [KEY_W-1:0] win_keys [WIN_MAX];
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
		span_t            span;
		int               first;
		int               last;
		int               size;
		int               step;
		int               base;
		int               phase_no;
		int               pick;
		bit               sorted;

		ladder = '{24'h000000, 24'h000100, 24'h00ABCD, 24'h123456,
			24'h555555, 24'hAAAAAA, 24'hFEDCBA, 24'hFFFFFF};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sorted ladder in slots 0..7, hits at both range ends and misses
		set_range(0, 7);
		for (int i = 0; i < 8; i++)
			send_req(OP_WRITE, IDX_W'(i), ladder[i]);
		send_req(OP_SEARCH, '0, 24'h000000);
		send_req(OP_SEARCH, '1, 24'hFFFFFF);
		send_req(OP_SEARCH, 15'h5555, 24'h123456);
		send_req(OP_SEARCH, 15'h2AAA, 24'h000001);
		send_req(OP_SEARCH, '0, 24'h800000);
		send_req(OP_WRITE, '1, 24'hFFFFFF);
		send_req(OP_WRITE, 15'h2AAA, 24'h5A5A5A);

		// one-entry span at the top slot
		set_range(32767, 32767);
		send_req(OP_SEARCH, '0, 24'hFFFFFF);
		send_req(OP_SEARCH, '0, 24'hFFFFFE);

		// empty spans
		set_range(5, 2);
		send_req(OP_SEARCH, '0, 24'h555555);
		set_range(32767, 0);
		send_req(OP_SEARCH, '0, 24'hFFFFFF);

		// break the ordering: hit at first probe, then keys off the path
		set_range(0, 7);
		send_req(OP_WRITE, 15'd3, 24'hFFFFFF);
		send_req(OP_SEARCH, '0, 24'hFFFFFF);
		send_req(OP_SEARCH, '0, 24'h123456);
		send_req(OP_SEARCH, '0, 24'h555555);

		base     = requests_sent;
		phase_no = 0;
		while (requests_sent - base < RANDOM_ITEMS) begin
			phase_no++;
			if (phase_no == 4)
				span = SPAN_WIDE;
			else
				case ($urandom_range(0, 9))
					0:       span = SPAN_EMPTY;
					1:       span = SPAN_LOW;
					2:       span = SPAN_HIGH;
					3:       span = SPAN_SINGLE;
					default: span = SPAN_MID;
				endcase
			size = $urandom_range(1, 64);
			case (span)
				SPAN_EMPTY: begin
					first = $urandom_range(1, 32767);
					last  = $urandom_range(0, first - 1);
					size  = 0;
				end
				SPAN_LOW: begin
					first = 0;
					last  = size - 1;
				end
				SPAN_HIGH: begin
					last  = 32767;
					first = 32768 - size;
				end
				SPAN_SINGLE: begin
					size  = 1;
					first = $urandom_range(0, 32767);
					last  = first;
				end
				SPAN_WIDE: begin
					size  = WIN_MAX;
					first = $urandom_range(0, 32768 - size);
					last  = first + size - 1;
				end
				default: begin
					first = $urandom_range(0, 32768 - size);
					last  = first + size - 1;
				end
			endcase
			set_range(first, last);
			if (phase_no == 2 || phase_no == 7)
				hold_asked++;

			// every slot of the span gets written before it can be probed
			if (size > 0) begin
				sorted = ($urandom_range(0, 9) != 0);
				step   = 16777215 / size;
				key    = KEY_W'($urandom_range(0, step));
				for (int i = 0; i < size; i++) begin
					if (!sorted)
						key = KEY_W'($urandom());
					win_keys[i] = key;
					send_req(OP_WRITE, IDX_W'(first + i), key);
					if (sorted && $urandom_range(0, 7) != 0)
						key = key + KEY_W'($urandom_range(0, step - 1));
				end
			end

			repeat ($urandom_range(20, 80)) begin
				pick = $urandom_range(0, 99);
				idx  = IDX_W'($urandom());
				if (pick < 10) begin
					key = KEY_W'($urandom());
					if (int'(idx) >= first && int'(idx) < first + size)
						win_keys[int'(idx) - first] = key;
					send_req(OP_WRITE, idx, key);
				end else begin
					if (size == 0 || pick >= 85)
						key = KEY_W'($urandom());
					else if (pick >= 75)
						key = win_keys[$urandom_range(0, size - 1)] +
							($urandom_range(0, 1) ? 24'h000001 : 24'hFFFFFF);
					else
						key = win_keys[$urandom_range(0, size - 1)];
					send_req(OP_SEARCH, idx, key);
				end
			end
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
